### src/teq_pkg.sv
package teq_pkg;

  localparam int ACTION_W    = 2;
  localparam int ID_W        = 16;
  localparam int TIME_W      = 48;
  localparam int STATUS_W    = 3;
  localparam int TOTAL_W     = 32;
  localparam int MAX_RESULTS = 32;
  localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_CANCEL = 2'd1,
    ACT_TICK   = 2'd2,
    ACT_NOP    = 2'd3
  } teq_action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ACCEPTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FIRED     = 3'd3,
    ST_NONE_DUE  = 3'd4
  } teq_status_t;

  // per-cell write strobes from the controller
  typedef struct packed {
    logic load;
    logic set_canc;
    logic clr_canc;
  } teq_cell_ctl_t;

endpackage

### src/teq_if.sv
interface teq_in_if;
  logic                        valid;
  logic                        ready;
  logic [teq_pkg::ACTION_W-1:0] action;
  logic [teq_pkg::ID_W-1:0]     timer_id;
  logic [teq_pkg::TIME_W-1:0]   expiry_time;
  logic [teq_pkg::TIME_W-1:0]   now_time;

  modport source (output valid, action, timer_id, expiry_time, now_time, input ready);
  modport sink   (input valid, action, timer_id, expiry_time, now_time, output ready);
endinterface

interface teq_out_if;
  logic                         valid;
  logic                         ready;
  logic [teq_pkg::STATUS_W-1:0] status;
  logic [teq_pkg::ID_W-1:0]     fired_id;
  logic [teq_pkg::TIME_W-1:0]   fired_expiry;
  logic                         last_of_run;
  logic [teq_pkg::TOTAL_W-1:0]  fired_total;
  logic [teq_pkg::TIME_W-1:0]   next_expiry;

  modport source (output valid, status, fired_id, fired_expiry, last_of_run, fired_total,
                  next_expiry, input ready);
  modport sink   (input valid, status, fired_id, fired_expiry, last_of_run, fired_total,
                  next_expiry, output ready);
endinterface

### src/teq_cell.sv
module teq_cell #(
  parameter int TIME_BITS = 48,
  parameter int ID_BITS   = 16,
  parameter int IDX_W     = 5,
  parameter int CELL_IDX  = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  teq_pkg::teq_cell_ctl_t ctl,
  input  logic                  occ,
  input  logic [TIME_BITS-1:0]  wr_exp,
  input  logic [ID_BITS-1:0]    wr_id,
  input  logic                  wr_canc,
  output logic [TIME_BITS-1:0]  exp_o,
  output logic [ID_BITS-1:0]    id_o,
  output logic                  canc_o,
  input  logic                  tin_vld,
  input  logic [TIME_BITS-1:0]  tin_exp,
  input  logic [ID_BITS-1:0]    tin_id,
  input  logic [IDX_W-1:0]      tin_idx,
  output logic                  tout_vld,
  output logic [TIME_BITS-1:0]  tout_exp,
  output logic [ID_BITS-1:0]    tout_id,
  output logic [IDX_W-1:0]      tout_idx
);

  logic [TIME_BITS-1:0] exp_r;
  logic [ID_BITS-1:0]   id_r;
  logic                 canc_r;
  logic                 canc_nxt;
  logic                 tok_vld_r;
  logic [TIME_BITS-1:0] tok_exp_r;
  logic [ID_BITS-1:0]   tok_id_r;
  logic [IDX_W-1:0]     tok_idx_r;
  logic                 take;

  // clear beats load: a slot that moves onto itself ends up live
  always_comb begin
    canc_nxt = canc_r;
    if (ctl.set_canc) canc_nxt = 1'b1;
    if (ctl.load)     canc_nxt = wr_canc;
    if (ctl.clr_canc) canc_nxt = 1'b0;
  end

  // keep the earlier cell on a full tie
  assign take = occ && !canc_r &&
                (!tin_vld || (exp_r < tin_exp) || ((exp_r == tin_exp) && (id_r < tin_id)));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      exp_r <= wr_exp;
      id_r  <= wr_id;
    end
    if (take) begin
      tok_exp_r <= exp_r;
      tok_id_r  <= id_r;
      tok_idx_r <= IDX_W'(CELL_IDX);
    end else begin
      tok_exp_r <= tin_exp;
      tok_id_r  <= tin_id;
      tok_idx_r <= tin_idx;
    end
    if (!rst_n) begin
      canc_r    <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      canc_r    <= canc_nxt;
      tok_vld_r <= take || tin_vld;
    end
  end

  assign exp_o    = exp_r;
  assign id_o     = id_r;
  assign canc_o   = canc_r;
  assign tout_vld = tok_vld_r;
  assign tout_exp = tok_exp_r;
  assign tout_id  = tok_id_r;
  assign tout_idx = tok_idx_r;

endmodule

### src/timer_expiry_queue.sv
// Timer expiry queue. Holds up to QUEUE_DEPTH pending timers (id plus absolute expiry) in a
// row of slot cells. An insert writes the next free slot, a cancel flags the live timer with
// that id in the lowest slot, and a tick first squeezes cancelled slots out (one slot step per
// cycle) and then fires due timers earliest first, ties to the lower id, at most 32 per tick.
// The earliest live timer is found by a comparison token that walks the cell row one cell per
// cycle, so every change of the queue is followed by a full search sweep: an insert or a found
// cancel gets one, a full insert, missed cancel or no-op gets none, and a tick gets one after
// the squeeze and one more after each fired timer. Every result carries the wrapping fire count
// and the earliest live expiry (all ones when none). A result waits in an output register, so
// the next transaction is taken while the previous result is still pending downstream.
module timer_expiry_queue #(
  parameter int QUEUE_DEPTH = 32,
  parameter int TIME_BITS   = 48,
  parameter int ID_BITS     = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  teq_in_if.sink    in_ch,
  teq_out_if.source out_ch
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMPACT,
    S_SWEEP,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t                       state_r;
  logic [CNT_W-1:0]             count_r;
  logic [CNT_W-1:0]             ptr_r;
  logic [CNT_W-1:0]             wait_r;
  logic [teq_pkg::RUN_W-1:0]    nres_r;
  logic [teq_pkg::TOTAL_W-1:0]  fire_cnt_r;
  logic [TIME_BITS-1:0]         next_r;
  logic [TIME_BITS-1:0]         now_r;
  logic                         run_r;
  logic                         to_decide_r;
  teq_pkg::teq_status_t         emit_st_r;
  logic [ID_BITS-1:0]           emit_id_r;
  logic [TIME_BITS-1:0]         emit_exp_r;

  logic                         out_vld_r;
  teq_pkg::teq_status_t         out_status_r;
  logic [teq_pkg::ID_W-1:0]     out_id_r;
  logic [teq_pkg::TIME_W-1:0]   out_exp_r;
  logic                         out_last_r;
  logic [teq_pkg::TOTAL_W-1:0]  out_total_r;
  logic [teq_pkg::TIME_W-1:0]   out_next_r;

  logic [TIME_BITS-1:0]         cell_exp [QUEUE_DEPTH];
  logic [ID_BITS-1:0]           cell_id  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0]       cell_canc;
  logic [QUEUE_DEPTH-1:0]       occ;
  logic [QUEUE_DEPTH-1:0]       match;
  teq_pkg::teq_cell_ctl_t       cell_ctl [QUEUE_DEPTH];

  logic                         tok_vld [QUEUE_DEPTH+1];
  logic [TIME_BITS-1:0]         tok_exp [QUEUE_DEPTH+1];
  logic [ID_BITS-1:0]           tok_id  [QUEUE_DEPTH+1];
  logic [IDX_W-1:0]             tok_idx [QUEUE_DEPTH+1];

  logic                         in_fire;
  logic [ID_BITS-1:0]           id_m;
  logic [TIME_BITS-1:0]         exp_m;
  logic [TIME_BITS-1:0]         now_m;
  logic                         full;
  logic                         any_match;
  logic [IDX_W-1:0]             first_idx;
  logic [IDX_W-1:0]             last_idx;
  logic [IDX_W-1:0]             rd_idx;
  logic [IDX_W-1:0]             rm_idx;
  logic [TIME_BITS-1:0]         rd_exp;
  logic [ID_BITS-1:0]           rd_id;
  logic                         rd_canc;
  logic                         ptr_canc;
  logic                         do_ins;
  logic                         do_cancel;
  logic                         do_remove;
  logic [TIME_BITS-1:0]         wr_exp;
  logic [ID_BITS-1:0]           wr_id;
  logic                         wr_canc;
  logic                         best_vld;
  logic [TIME_BITS-1:0]         best_exp;
  logic [ID_BITS-1:0]           best_id;
  logic [IDX_W-1:0]             best_idx;
  logic                         due;
  logic                         out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign id_m        = ID_BITS'(in_ch.timer_id);
  assign exp_m       = TIME_BITS'(in_ch.expiry_time);
  assign now_m       = TIME_BITS'(in_ch.now_time);

  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign rd_exp   = cell_exp[rd_idx];
  assign rd_id    = cell_id[rd_idx];
  assign rd_canc  = cell_canc[rd_idx];
  assign ptr_canc = cell_canc[ptr_r[IDX_W-1:0]];

  assign tok_vld[0] = 1'b0;
  assign tok_exp[0] = '0;
  assign tok_id[0]  = '0;
  assign tok_idx[0] = '0;

  assign best_vld = tok_vld[QUEUE_DEPTH];
  assign best_exp = tok_exp[QUEUE_DEPTH];
  assign best_id  = tok_id[QUEUE_DEPTH];
  assign best_idx = tok_idx[QUEUE_DEPTH];

  assign due      = best_vld && (best_exp <= now_r) &&
                    (nres_r < teq_pkg::RUN_W'(teq_pkg::MAX_RESULTS));
  assign out_free = !out_vld_r || out_ch.ready;

  // lowest live slot carrying the cancel id
  always_comb begin
    any_match = 1'b0;
    first_idx = '0;
    for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
      if (match[i]) begin
        any_match = 1'b1;
        first_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    do_ins    = 1'b0;
    do_cancel = 1'b0;
    do_remove = 1'b0;
    rm_idx    = '0;
    rd_idx    = last_idx;
    case (state_r)
      S_IDLE: begin
        rd_idx = first_idx;
        if (in_fire) begin
          do_ins    = (in_ch.action == teq_pkg::ACT_INSERT) && !full;
          do_cancel = (in_ch.action == teq_pkg::ACT_CANCEL) && any_match;
        end
      end
      S_COMPACT: begin
        if ((ptr_r < count_r) && ptr_canc) begin
          do_remove = 1'b1;
          rm_idx    = ptr_r[IDX_W-1:0];
        end
      end
      S_DECIDE: begin
        if (due) begin
          do_remove = 1'b1;
          rm_idx    = best_idx;
        end
      end
      default: begin
      end
    endcase
  end

  // removal moves the last slot into the hole
  assign wr_exp  = do_ins ? exp_m : rd_exp;
  assign wr_id   = do_ins ? id_m : rd_id;
  assign wr_canc = do_ins ? 1'b0 : rd_canc;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign occ[i]   = (count_r > CNT_W'(i));
    assign match[i] = occ[i] && !cell_canc[i] && (cell_id[i] == id_m);

    assign cell_ctl[i].load     = (do_ins && (count_r == CNT_W'(i))) ||
                                  (do_remove && (rm_idx == IDX_W'(i)));
    assign cell_ctl[i].set_canc = do_cancel && (first_idx == IDX_W'(i));
    assign cell_ctl[i].clr_canc = do_remove && (last_idx == IDX_W'(i));

    teq_cell #(
      .TIME_BITS (TIME_BITS),
      .ID_BITS   (ID_BITS),
      .IDX_W     (IDX_W),
      .CELL_IDX  (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl[i]),
      .occ      (occ[i]),
      .wr_exp   (wr_exp),
      .wr_id    (wr_id),
      .wr_canc  (wr_canc),
      .exp_o    (cell_exp[i]),
      .id_o     (cell_id[i]),
      .canc_o   (cell_canc[i]),
      .tin_vld  (tok_vld[i]),
      .tin_exp  (tok_exp[i]),
      .tin_id   (tok_id[i]),
      .tin_idx  (tok_idx[i]),
      .tout_vld (tok_vld[i+1]),
      .tout_exp (tok_exp[i+1]),
      .tout_id  (tok_id[i+1]),
      .tout_idx (tok_idx[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      fire_cnt_r <= '0;
      next_r     <= '1;
      out_vld_r  <= 1'b0;
    end else begin
      if (out_vld_r && out_ch.ready && (state_r != S_EMIT)) out_vld_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            run_r       <= (in_ch.action == teq_pkg::ACT_TICK);
            to_decide_r <= 1'b0;
            case (in_ch.action)
              teq_pkg::ACT_INSERT: begin
                emit_id_r  <= id_m;
                emit_exp_r <= exp_m;
                if (full) begin
                  emit_st_r <= teq_pkg::ST_FULL;
                  state_r   <= S_EMIT;
                end else begin
                  emit_st_r <= teq_pkg::ST_ACCEPTED;
                  count_r   <= count_r + CNT_W'(1);
                  wait_r    <= CNT_W'(QUEUE_DEPTH);
                  state_r   <= S_SWEEP;
                end
              end
              teq_pkg::ACT_CANCEL: begin
                emit_id_r <= id_m;
                if (any_match) begin
                  emit_st_r  <= teq_pkg::ST_ACCEPTED;
                  emit_exp_r <= rd_exp;
                  wait_r     <= CNT_W'(QUEUE_DEPTH);
                  state_r    <= S_SWEEP;
                end else begin
                  emit_st_r  <= teq_pkg::ST_NOT_FOUND;
                  emit_exp_r <= '0;
                  state_r    <= S_EMIT;
                end
              end
              teq_pkg::ACT_TICK: begin
                now_r   <= now_m;
                ptr_r   <= '0;
                nres_r  <= '0;
                state_r <= S_COMPACT;
              end
              default: begin
                emit_st_r  <= teq_pkg::ST_NONE_DUE;
                emit_id_r  <= '0;
                emit_exp_r <= '0;
                state_r    <= S_EMIT;
              end
            endcase
          end
        end
        S_COMPACT: begin
          if (ptr_r < count_r) begin
            // hold the pointer after a move: the slot that came in may be cancelled too
            if (ptr_canc) count_r <= count_r - CNT_W'(1);
            else          ptr_r   <= ptr_r + CNT_W'(1);
          end else begin
            wait_r      <= CNT_W'(QUEUE_DEPTH);
            to_decide_r <= 1'b1;
            state_r     <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          // wait for the token to clear the last cell
          if (wait_r == '0) begin
            next_r  <= best_vld ? best_exp : '1;
            state_r <= to_decide_r ? S_DECIDE : S_EMIT;
          end else begin
            wait_r <= wait_r - CNT_W'(1);
          end
        end
        S_DECIDE: begin
          if (due) begin
            count_r     <= count_r - CNT_W'(1);
            fire_cnt_r  <= fire_cnt_r + teq_pkg::TOTAL_W'(1);
            nres_r      <= nres_r + teq_pkg::RUN_W'(1);
            emit_st_r   <= teq_pkg::ST_FIRED;
            emit_id_r   <= best_id;
            emit_exp_r  <= best_exp;
            wait_r      <= CNT_W'(QUEUE_DEPTH);
            to_decide_r <= 1'b0;
            state_r     <= S_SWEEP;
          end else begin
            emit_st_r  <= teq_pkg::ST_NONE_DUE;
            emit_id_r  <= '0;
            emit_exp_r <= '0;
            run_r      <= 1'b0;
            state_r    <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_vld_r    <= 1'b1;
            out_status_r <= emit_st_r;
            out_id_r     <= teq_pkg::ID_W'(emit_id_r);
            out_exp_r    <= teq_pkg::TIME_W'(emit_exp_r);
            out_last_r   <= !(run_r && due);
            out_total_r  <= fire_cnt_r;
            out_next_r   <= teq_pkg::TIME_W'(next_r);
            state_r      <= (run_r && due) ? S_DECIDE : S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.fired_id     = out_id_r;
  assign out_ch.fired_expiry = out_exp_r;
  assign out_ch.last_of_run  = out_last_r;
  assign out_ch.fired_total  = out_total_r;
  assign out_ch.next_expiry  = out_next_r;

endmodule

### tb/sv/tb_timer_expiry_queue.sv
`timescale 1ns / 1ps

typedef struct packed {
  teq_pkg::teq_status_t              status;
  logic [teq_pkg::ID_W-1:0]          tid;
  logic [teq_pkg::TIME_W-1:0]        expiry;
  logic                              last_flag;
  logic [teq_pkg::TOTAL_W-1:0]       total;
  logic [teq_pkg::TIME_W-1:0]        next_exp;
} teq_resp_t;

class timer_queue_scoreboard;
  localparam int SLOTS = 32;
  localparam logic [teq_pkg::TIME_W-1:0] NO_EXPIRY = '1;

  // mirror of the timer slots
  logic [teq_pkg::TIME_W-1:0]  t_exp [SLOTS];
  logic [teq_pkg::ID_W-1:0]    t_id  [SLOTS];
  bit                          t_canc[SLOTS];
  int                          n_held;
  logic [teq_pkg::TOTAL_W-1:0] fire_cnt;
  teq_resp_t                   pending_resps[$];

  int unsigned errors, n_req, n_resp, n_ins, n_canc, n_tick, n_nop;
  int unsigned n_fired, n_full, n_miss, n_quiet, max_burst;

  function new();
    n_held   = 0;
    fire_cnt = '0;
    foreach (t_canc[i]) t_canc[i] = 1'b0;
  endfunction

  // earliest live timer, ties to the lower id; -1 when none
  function int soonest();
    int best;
    best = -1;
    for (int i = 0; i < n_held; i++) begin
      if (t_canc[i]) continue;
      if (best < 0 || t_exp[i] < t_exp[best] ||
          (t_exp[i] == t_exp[best] && t_id[i] < t_id[best]))
        best = i;
    end
    return best;
  endfunction

  function logic [teq_pkg::TIME_W-1:0] head_expiry();
    int m;
    m = soonest();
    return (m < 0) ? NO_EXPIRY : t_exp[m];
  endfunction

  // move the last occupied slot into the hole
  function void evict(int i);
    int tail;
    tail = n_held - 1;
    t_exp[i]     = t_exp[tail];
    t_id[i]      = t_id[tail];
    t_canc[i]    = t_canc[tail];
    t_canc[tail] = 1'b0;
    n_held       = tail;
  endfunction

  function void push_resp(teq_pkg::teq_status_t st, logic [teq_pkg::ID_W-1:0] id,
                          logic [teq_pkg::TIME_W-1:0] ex);
    teq_resp_t r;
    r.status    = st;
    r.tid       = id;
    r.expiry    = ex;
    r.last_flag = 1'b0;
    r.total     = fire_cnt;
    r.next_exp  = head_expiry();
    pending_resps.insert(pending_resps.size(), r);
    n_resp++;
  endfunction

  function void note_request(teq_pkg::teq_action_t act, logic [teq_pkg::ID_W-1:0] id,
                             logic [teq_pkg::TIME_W-1:0] ex, logic [teq_pkg::TIME_W-1:0] nw);
    int i, m, burst;
    bit hit;
    logic [teq_pkg::ID_W-1:0] fid;
    logic [teq_pkg::TIME_W-1:0] fexp;
    burst = 0;
    hit   = 1'b0;
    n_req++;
    case (act)
      teq_pkg::ACT_INSERT: begin
        n_ins++;
        if (n_held >= SLOTS) begin
          n_full++;
          push_resp(teq_pkg::ST_FULL, id, ex);
        end else begin
          t_exp[n_held]  = ex;
          t_id[n_held]   = id;
          t_canc[n_held] = 1'b0;
          n_held++;
          push_resp(teq_pkg::ST_ACCEPTED, id, ex);
        end
      end
      teq_pkg::ACT_CANCEL: begin
        n_canc++;
        for (i = 0; i < n_held && !hit; i++) begin
          if (!t_canc[i] && t_id[i] == id) begin
            t_canc[i] = 1'b1;
            hit = 1'b1;
            push_resp(teq_pkg::ST_ACCEPTED, id, t_exp[i]);
          end
        end
        if (!hit) begin
          n_miss++;
          push_resp(teq_pkg::ST_NOT_FOUND, id, '0);
        end
      end
      teq_pkg::ACT_TICK: begin
        n_tick++;
        // drop cancelled timers before anything fires
        i = 0;
        while (i < n_held) begin
          if (t_canc[i]) evict(i);
          else i++;
        end
        while (burst < teq_pkg::MAX_RESULTS) begin
          m = soonest();
          if (m < 0 || t_exp[m] > nw) break;
          fid  = t_id[m];
          fexp = t_exp[m];
          evict(m);
          fire_cnt = fire_cnt + teq_pkg::TOTAL_W'(1);
          burst++;
          push_resp(teq_pkg::ST_FIRED, fid, fexp);
        end
        if (burst == 0) begin
          n_quiet++;
          push_resp(teq_pkg::ST_NONE_DUE, '0, '0);
        end
        n_fired += burst;
        if (burst > max_burst) max_burst = burst;
      end
      default: begin
        n_nop++;
        push_resp(teq_pkg::ST_NONE_DUE, '0, '0);
      end
    endcase
    pending_resps[pending_resps.size() - 1].last_flag = 1'b1;
  endfunction

  function void check_result(teq_resp_t got);
    teq_resp_t want;
    if (pending_resps.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected response status=%0d id=%h exp=%h", $realtime,
                 got.status, got.tid, got.expiry);
      return;
    end
    want = pending_resps.pop_front();
    if (got.status !== want.status || got.tid !== want.tid || got.expiry !== want.expiry ||
        got.last_flag !== want.last_flag || got.total !== want.total ||
        got.next_exp !== want.next_exp) begin
      errors++;
      if (errors <= 10) begin
        $display("%0t: response mismatch", $realtime);
        $display("  exp: st=%0d id=%h exp=%h last=%b total=%0d next=%h", want.status,
                 want.tid, want.expiry, want.last_flag, want.total, want.next_exp);
        $display("  got: st=%0d id=%h exp=%h last=%b total=%0d next=%h", got.status,
                 got.tid, got.expiry, got.last_flag, got.total, got.next_exp);
      end
    end
  endfunction

  function int outstanding();
    return pending_resps.size();
  endfunction

  function void close_out();
    if (pending_resps.size() != 0) begin
      errors += pending_resps.size();
      $display("%0d expected responses never arrived", pending_resps.size());
    end
  endfunction
endclass

module tb_timer_expiry_queue;
  localparam int HALF_PERIOD    = 5;
  localparam int QDEPTH         = 32;
  localparam int RANDOM_ITEMS   = 360;
  localparam int CALM_ITEMS     = 60;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam logic [teq_pkg::TIME_W-1:0] TIME_MAX = '1;

  logic clk = 1'b0;
  logic rst_n;

  teq_in_if  in_ch ();
  teq_out_if out_ch ();

  timer_expiry_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .TIME_BITS  (teq_pkg::TIME_W),
    .ID_BITS    (teq_pkg::ID_W)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  timer_queue_scoreboard sb = new();

  bit idle_on;
  bit hold_req;
  int n_sent;
  int n_holds;
  int quiet;

  always #HALF_PERIOD clk = ~clk;

  function automatic logic [teq_pkg::TIME_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[teq_pkg::TIME_W-1:0];
  endfunction

  function automatic logic [teq_pkg::ID_W-1:0] pick_id();
    if ($urandom_range(0, 3) == 0) return teq_pkg::ID_W'($urandom_range(0, 65535));
    return teq_pkg::ID_W'($urandom_range(0, 15));
  endfunction

  // present one transaction and hold it until the block takes it
  task automatic send_op(teq_pkg::teq_action_t act, logic [teq_pkg::ID_W-1:0] id,
                         logic [teq_pkg::TIME_W-1:0] ex, logic [teq_pkg::TIME_W-1:0] nw);
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.timer_id    <= id;
    in_ch.expiry_time <= ex;
    in_ch.now_time    <= nw;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_request(act, id, ex, nw);
    n_sent++;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic run_directed();
    send_op(teq_pkg::ACT_TICK, '0, rand48(), '0);
    send_op(teq_pkg::ACT_NOP, 16'h1111, rand48(), rand48());
    send_op(teq_pkg::ACT_CANCEL, 16'h1234, '0, '0);
    send_op(teq_pkg::ACT_INSERT, 16'h0000, TIME_MAX, '0);
    send_op(teq_pkg::ACT_INSERT, 16'hFFFF, '0, TIME_MAX);
    send_op(teq_pkg::ACT_INSERT, 16'd5, 48'd100, '0);
    send_op(teq_pkg::ACT_INSERT, 16'd3, 48'd100, '0);
    send_op(teq_pkg::ACT_INSERT, 16'd5, 48'd50, '0);
    // duplicate ids: lowest slot first, then the other, then nothing left
    send_op(teq_pkg::ACT_CANCEL, 16'd5, '0, '0);
    send_op(teq_pkg::ACT_CANCEL, 16'd5, '0, '0);
    send_op(teq_pkg::ACT_CANCEL, 16'd5, '0, '0);
    send_op(teq_pkg::ACT_NOP, '0, '0, '0);
    send_op(teq_pkg::ACT_TICK, '0, '0, 48'd99);
    send_op(teq_pkg::ACT_TICK, '0, '0, 48'd100);
    send_op(teq_pkg::ACT_TICK, '0, '0, TIME_MAX);
    send_op(teq_pkg::ACT_TICK, '0, '0, TIME_MAX);
    send_op(teq_pkg::ACT_INSERT, 16'hAAAA, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA);
    send_op(teq_pkg::ACT_INSERT, 16'h5555, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555);
    send_op(teq_pkg::ACT_CANCEL, 16'hAAAA, '0, '0);
    send_op(teq_pkg::ACT_TICK, '0, '0, '0);
  endtask

  // fill every slot, overflow, cancel up to three, then tick to fire a burst
  task automatic fill_and_drain(inout logic [teq_pkg::TIME_W-1:0] base);
    int nc;
    while (sb.n_held < QDEPTH)
      send_op(teq_pkg::ACT_INSERT, pick_id(), base + $urandom_range(0, 200), rand48());
    repeat ($urandom_range(1, 2))
      send_op(teq_pkg::ACT_INSERT, pick_id(), base + $urandom_range(0, 200), rand48());
    nc = $urandom_range(0, 3);
    repeat (nc)
      send_op(teq_pkg::ACT_CANCEL, sb.t_id[$urandom_range(0, sb.n_held - 1)], rand48(),
              rand48());
    // cancelled timers still hold their slots
    if (nc > 0) send_op(teq_pkg::ACT_INSERT, pick_id(), base, rand48());
    send_op(teq_pkg::ACT_TICK, pick_id(), rand48(),
            ($urandom_range(0, 3) == 0) ? TIME_MAX : base + $urandom_range(0, 220));
    base = base + 256;
  endtask

  task automatic mixed_ops(inout logic [teq_pkg::TIME_W-1:0] base);
    int r;
    logic [teq_pkg::ID_W-1:0] id;
    repeat ($urandom_range(8, 20)) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send_op(teq_pkg::ACT_INSERT, pick_id(),
                (r < 4) ? rand48() : base + $urandom_range(0, 300), rand48());
      end else if (r < 65) begin
        if (sb.n_held > 0 && $urandom_range(0, 4) != 0)
          id = sb.t_id[$urandom_range(0, sb.n_held - 1)];
        else
          id = pick_id();
        send_op(teq_pkg::ACT_CANCEL, id, rand48(), rand48());
      end else if (r < 95) begin
        base = base + $urandom_range(0, 80);
        send_op(teq_pkg::ACT_TICK, pick_id(), rand48(), (r >= 93) ? rand48() : base);
      end else begin
        send_op(teq_pkg::ACT_NOP, pick_id(), rand48(), rand48());
      end
    end
  endtask

  task automatic run_random();
    int start;
    bit hold_done;
    logic [teq_pkg::TIME_W-1:0] base;
    start     = n_sent;
    hold_done = 1'b0;
    base      = 1000;
    while (n_sent - start < RANDOM_ITEMS) begin
      if (n_sent - start >= RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      if (!hold_done && n_sent - start >= RANDOM_ITEMS / 3) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 4) == 0) fill_and_drain(base);
      else mixed_ops(base);
    end
  endtask

  // output side pacing: random stalls plus one long hold-off
  initial begin : sink_pacing
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
        n_holds++;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    teq_resp_t got;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status    = teq_pkg::teq_status_t'(out_ch.status);
      got.tid       = out_ch.fired_id;
      got.expiry    = out_ch.fired_expiry;
      got.last_flag = out_ch.last_of_run;
      got.total     = out_ch.fired_total;
      got.next_exp  = out_ch.next_expiry;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
        (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", quiet);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin : stimulus
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.action      <= teq_pkg::ACT_NOP;
    in_ch.timer_id    <= '0;
    in_ch.expiry_time <= '0;
    in_ch.now_time    <= '0;
    idle_on  = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    in_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    $display("ran %0d requests (%0d insert, %0d cancel, %0d tick, %0d no-op), %0d responses",
             sb.n_req, sb.n_ins, sb.n_canc, sb.n_tick, sb.n_nop, sb.n_resp);
    $display("fired %0d (largest burst %0d), full %0d, missed cancel %0d, idle tick %0d, %0d long hold-off",
             sb.n_fired, sb.max_burst, sb.n_full, sb.n_miss, sb.n_quiet, n_holds);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
